FILE: sv/flet_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package flet_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W       = (CNT_W > 7) ? CNT_W : 7;

    localparam int PADDR_W     = 3;
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic [6:0] CAPACITY_RESET = 7'd64;

    localparam logic [23:0] AGE_MAX    = 24'hFFFFFF;
    localparam logic [16:0] ALPHA_ONE  = 17'd65536;
    localparam logic [16:0] ALPHA_DROP = 17'd65;
    localparam logic [4:0]  DIV_STEPS  = 5'd17;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_TICK   = 2'd3;

    typedef struct packed {
        logic [31:0] id;
        logic [23:0] age;
        logic [23:0] lifetime;
        logic [15:0] fade_time;
        logic        fading;
        logic [16:0] alpha;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef enum logic [1:0] {
        WSEL_NEW,
        WSEL_RAW,
        WSEL_WORK
    } wsel_t;

    typedef enum logic [1:0] {
        OUT_ADD_OK,
        OUT_ADD_FULL,
        OUT_PLAIN,
        OUT_ENTRY
    } out_kind_t;

    typedef struct packed {
        logic             load_in;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        wsel_t            wr_sel;
        logic             eval;
        logic             div_start;
        logic             alpha_take;
        logic             out_load;
        out_kind_t        out_kind;
        logic [31:0]      out_id;
        logic [6:0]       out_count;
        logic             out_last;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic drop;
        logic id_match;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

FILE: sv/flet_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module flet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/flet_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit a cycle: quot = floor(num * 65536 / den), num <= den.
module flet_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [15:0] num,
    input  wire logic [15:0] den,
    output logic             done,
    output logic [16:0]      quot
);

    import flet_pkg::*;

    logic [16:0] rem_reg, rem_next;
    logic [15:0] den_reg;
    logic [16:0] q_reg, q_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic        ge;
    logic [16:0] diff;

    always_comb
    begin
        ge        = rem_reg >= {1'b0, den_reg};
        diff      = ge ? rem_reg - {1'b0, den_reg} : rem_reg;
        rem_next  = {diff[15:0], 1'b0};
        q_next    = {q_reg[15:0], ge};
        cnt_next  = cnt_reg - 5'd1;
        done_next = (cnt_reg == 5'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= DIV_STEPS;
            done_reg <= 1'b0;
        end
        else if (cnt_reg != 5'd0)
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            q_reg   <= '0;
        end
        else if (cnt_reg != 5'd0)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

FILE: sv/flet_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module flet_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire flet_pkg::cmd_t     cmd,
    output flet_pkg::status_t       status,
    input  wire logic signed [23:0] lifetime,
    input  wire logic [15:0]        fade_time,
    input  wire logic [31:0]        remove_id,
    input  wire logic [15:0]        dt,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    accepted,
    output logic [31:0]             new_id,
    output logic                    entry_valid,
    output logic [31:0]             entry_id,
    output logic [16:0]             entry_alpha,
    output logic [6:0]              active_count,
    output logic                    last
);

    import flet_pkg::*;

    logic [23:0] life_reg;
    logic [15:0] fade_reg;
    logic [31:0] rid_reg;
    logic [15:0] dt_reg;

    slot_t rd_slot, wr_slot, eval_slot, work_reg;
    logic [SLOT_W-1:0] rd_data;

    logic [24:0] age_sum;
    logic [23:0] age_new, excess;
    logic        infinite, reached, fade_now, need_div;
    logic [15:0] div_num;
    logic        div_done;
    logic [16:0] div_quot;

    logic        out_valid_reg;
    logic        acc_reg, ev_reg, last_reg;
    logic [31:0] nid_reg, eid_reg;
    logic [16:0] alpha_reg;
    logic [6:0]  cnt_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            life_reg <= lifetime;
            fade_reg <= fade_time;
            rid_reg  <= remove_id;
            dt_reg   <= dt;
        end
    end

    assign rd_slot = slot_t'(rd_data);

    // Age, fade flag and the cheap alpha cases of one entry.
    always_comb
    begin
        age_sum   = {1'b0, rd_slot.age} + {9'd0, dt_reg};
        age_new   = age_sum[24] ? AGE_MAX : age_sum[23:0];
        infinite  = rd_slot.lifetime[23];
        reached   = age_new >= rd_slot.lifetime;
        fade_now  = rd_slot.fading | reached;
        excess    = reached ? age_new - rd_slot.lifetime : 24'd0;
        need_div  = 1'b0;
        eval_slot = rd_slot;
        if (!infinite)
        begin
            eval_slot.age    = age_new;
            eval_slot.fading = fade_now;
            if (fade_now && rd_slot.fade_time != 16'd0)
            begin
                if (excess >= {8'd0, rd_slot.fade_time})
                begin
                    eval_slot.alpha = '0;
                end
                else
                begin
                    need_div = 1'b1;
                end
            end
        end
        div_num = rd_slot.fade_time - excess[15:0];
    end

    flet_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (rd_slot.fade_time),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            work_reg <= eval_slot;
        end
        else if (cmd.alpha_take)
        begin
            work_reg.alpha <= div_quot;
        end
    end

    always_comb
    begin
        case (cmd.wr_sel)
            WSEL_NEW:
            begin
                wr_slot.id        = cmd.out_id;
                wr_slot.age       = '0;
                wr_slot.lifetime  = life_reg;
                wr_slot.fade_time = fade_reg;
                wr_slot.fading    = 1'b0;
                wr_slot.alpha     = ALPHA_ONE;
            end
            WSEL_WORK: wr_slot = work_reg;
            default:   wr_slot = rd_slot;
        endcase
    end

    flet_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (cmd.wr_addr),
        .wr_data (wr_slot),
        .rd_en   (cmd.rd_en),
        .rd_addr (cmd.rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            acc_reg   <= (cmd.out_kind == OUT_ADD_OK);
            nid_reg   <= (cmd.out_kind == OUT_ADD_OK) ? cmd.out_id :
                         (cmd.out_kind == OUT_ADD_FULL) ? 32'hFFFFFFFF : 32'd0;
            ev_reg    <= (cmd.out_kind == OUT_ENTRY);
            eid_reg   <= (cmd.out_kind == OUT_ENTRY) ? rd_slot.id : 32'd0;
            alpha_reg <= (cmd.out_kind == OUT_ENTRY) ? rd_slot.alpha : 17'd0;
            cnt_reg   <= cmd.out_count;
            last_reg  <= cmd.out_last;
        end
    end

    always_comb
    begin
        status.need_div = need_div;
        status.div_done = div_done;
        status.drop     = work_reg.fading && (work_reg.alpha <= ALPHA_DROP);
        status.id_match = (rd_slot.id == rid_reg);
        status.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid    = out_valid_reg;
    assign accepted     = acc_reg;
    assign new_id       = nid_reg;
    assign entry_valid  = ev_reg;
    assign entry_id     = eid_reg;
    assign entry_alpha  = alpha_reg;
    assign active_count = cnt_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

FILE: sv/flet_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module flet_ctrl (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [flet_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [1:0]                   mode,
    output flet_pkg::cmd_t                    cmd,
    input  wire flet_pkg::status_t            status
);

    import flet_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_RD,
        S_RM,
        S_EV,
        S_DIV,
        S_WB,
        S_LRD,
        S_LOUT,
        S_PLAIN
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] w_reg, w_next;
    logic [31:0]      id_reg, id_next;
    logic             tick_reg, tick_next;
    logic [6:0]       cap_reg;
    logic [CNT_W-1:0] limit;
    logic             list_last;

    always_comb
    begin
        if (CMP_W'(cap_reg) < CMP_W'(MAX_ENTRIES))
        begin
            limit = CNT_W'(cap_reg);
        end
        else
        begin
            limit = CNT_W'(MAX_ENTRIES);
        end
    end

    assign list_last = (i_reg + CNT_W'(1)) == count_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        i_next     = i_reg;
        w_next     = w_reg;
        id_next    = id_reg;
        tick_next  = tick_reg;
        cmd           = '0;
        cmd.wr_sel    = WSEL_RAW;
        cmd.out_kind  = OUT_PLAIN;
        cmd.rd_addr   = i_reg[IDX_W-1:0];
        cmd.wr_addr   = w_reg[IDX_W-1:0];
        cmd.out_id    = id_reg;
        cmd.out_count = 7'(count_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    i_next      = '0;
                    w_next      = '0;
                    tick_next   = (mode == MODE_TICK);
                    unique case (mode)
                        MODE_ADD:    state_next = S_ADD;
                        MODE_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_PLAIN;
                        end
                        default:     state_next = S_RD;
                    endcase
                end
            end
            S_ADD:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    if (count_reg < limit)
                    begin
                        cmd.wr_en     = 1'b1;
                        cmd.wr_sel    = WSEL_NEW;
                        cmd.wr_addr   = count_reg[IDX_W-1:0];
                        cmd.out_kind  = OUT_ADD_OK;
                        cmd.out_count = 7'(count_reg + CNT_W'(1));
                        count_next    = count_reg + CNT_W'(1);
                        id_next       = id_reg + 32'd1;
                    end
                    else
                    begin
                        cmd.out_kind = OUT_ADD_FULL;
                    end
                    state_next = S_IDLE;
                end
            end
            S_RD:
            begin
                if (i_reg == count_reg)
                begin
                    count_next = w_reg;
                    i_next     = '0;
                    state_next = (tick_reg && w_reg != '0) ? S_LRD : S_PLAIN;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = tick_reg ? S_EV : S_RM;
                end
            end
            S_RM:
            begin
                if (!status.id_match)
                begin
                    cmd.wr_en = 1'b1;
                    w_next    = w_reg + CNT_W'(1);
                end
                i_next     = i_reg + CNT_W'(1);
                state_next = S_RD;
            end
            S_EV:
            begin
                cmd.eval = 1'b1;
                if (status.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = S_WB;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.alpha_take = 1'b1;
                    state_next     = S_WB;
                end
            end
            S_WB:
            begin
                if (!status.drop)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WSEL_WORK;
                    w_next     = w_reg + CNT_W'(1);
                end
                i_next     = i_reg + CNT_W'(1);
                state_next = S_RD;
            end
            S_LRD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_LOUT;
            end
            S_LOUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = OUT_ENTRY;
                    cmd.out_last = list_last;
                    i_next       = i_reg + CNT_W'(1);
                    state_next   = list_last ? S_IDLE : S_LRD;
                end
            end
            S_PLAIN:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            i_reg     <= '0;
            w_reg     <= '0;
            id_reg    <= '0;
            tick_reg  <= 1'b0;
            cap_reg   <= CAPACITY_RESET;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            i_reg     <= i_next;
            w_reg     <= w_next;
            id_reg    <= id_next;
            tick_reg  <= tick_next;
            if (psel && penable && pwrite && paddr[2] == REG_CAPACITY)
            begin
                cap_reg <= pwdata[6:0];
            end
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_CAPACITY) ? {25'd0, cap_reg} : 32'd0;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above table size");

    // Only meaningful while walking the table; listing reuses the read index.
    a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD || state_reg == S_RM || state_reg == S_EV ||
         state_reg == S_DIV || state_reg == S_WB) |-> w_reg <= i_reg)
        else $error("write index passed read index");

    a_add_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD && cmd.wr_en) |-> count_reg < limit)
        else $error("add stored past the limit");

    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg != S_IDLE)
        else $error("transfer taken without work");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> state_reg == S_DIV)
        else $error("divider started outside division wait");
`endif

endmodule

`default_nettype wire

FILE: sv/fading_lifetime_entry_table.sv
// Steps: add and clear go straight to the result; remove walks every stored entry.
// Tick: walks every entry, with a pass through the one-bit-a-cycle divider for an
// entry whose alpha needs it, closes the walk, then lists each surviving entry.
// Throughput: one item at a time.
// Reset: asynchronous, active low; empties the table, zeroes the id counter, capacity 64.
`timescale 1ns / 1ps
`default_nettype none

module fading_lifetime_entry_table (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [flet_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    // input channel
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [1:0]                   mode,
    input  wire logic signed [23:0]           lifetime,
    input  wire logic [15:0]                  fade_time,
    input  wire logic [31:0]                  remove_id,
    input  wire logic [15:0]                  dt,
    // result channel
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              accepted,
    output logic [31:0]                       new_id,
    output logic                              entry_valid,
    output logic [31:0]                       entry_id,
    output logic [16:0]                       entry_alpha,
    output logic [6:0]                        active_count,
    output logic                              last
);

    import flet_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer: decodes each input transfer, walks the slot memory for
    // remove and tick (compacting in place), then lists the survivors of a tick.
    flet_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .cmd      (cmd),
        .status   (status)
    );

    // Slot memory, aging and fade math, divider and the output register
    // that holds a finished result until its transfer.
    flet_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .lifetime     (lifetime),
        .fade_time    (fade_time),
        .remove_id    (remove_id),
        .dt           (dt),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .accepted     (accepted),
        .new_id       (new_id),
        .entry_valid  (entry_valid),
        .entry_id     (entry_id),
        .entry_alpha  (entry_alpha),
        .active_count (active_count),
        .last         (last)
    );

endmodule

`default_nettype wire
